// ----- hdl/lbmzh_pkg.sv -----
// ----------------------------------------------------------------------------
// lbmzh_pkg
// Shared constants, types and a velocity clamp for the D3Q15 moving-wall velocity boundary.
// ----------------------------------------------------------------------------
package lbmzh_pkg;

   localparam int VEL_W     = 16;  // wall velocity, signed Q1.15
   localparam int K_W       = 20;  // signed velocity factor per lane
   localparam int KMAG_W    = 18;  // magnitude of that factor
   localparam int D_W       = 16;  // 32768 -+ normal velocity
   localparam int M_W       = 20;  // divisor 12 * D
   localparam int LANES     = 5;   // axis + four diagonals
   localparam int TERM_W    = 62;  // correction term, clamped to +-2^60
   localparam int CAP_BIT   = 60;
   localparam int CSR_IDX_W = 3;

   localparam int LANE_AXIS = 0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOWER_VEL_X = 3'd0,
      REG_LOWER_VEL_Y = 3'd1,
      REG_LOWER_VEL_Z = 3'd2,
      REG_UPPER_VEL_X = 3'd3,
      REG_UPPER_VEL_Y = 3'd4,
      REG_UPPER_VEL_Z = 3'd5
   } csr_reg_type;

   typedef logic signed [VEL_W-1:0] vel_type;

   // most negative code maps to -32767 so the divisor stays nonzero
   function automatic vel_type clamp_vel(input logic [VEL_W-1:0] raw);
      vel_type v;
      v = vel_type'(raw);
      if (raw == {1'b1, {(VEL_W-1){1'b0}}}) begin
         v = vel_type'({1'b1, {(VEL_W-2){1'b0}}, 1'b1});
      end
      return v;
   endfunction

endpackage

// ----- hdl/lbmzh_req_if.sv -----
// ----------------------------------------------------------------------------
// lbmzh_req_if
// Request channel: known distributions of one wall node.
// ----------------------------------------------------------------------------
interface lbmzh_req_if #(
   parameter int DIST_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [DIST_WIDTH-1:0] rest_dist;
   logic signed [DIST_WIDTH-1:0] pos_x_dist;
   logic signed [DIST_WIDTH-1:0] pos_z_dist;
   logic signed [DIST_WIDTH-1:0] neg_x_dist;
   logic signed [DIST_WIDTH-1:0] neg_z_dist;
   logic signed [DIST_WIDTH-1:0] known_axis;
   logic signed [DIST_WIDTH-1:0] known_diag_a;
   logic signed [DIST_WIDTH-1:0] known_diag_b;
   logic signed [DIST_WIDTH-1:0] known_diag_c;
   logic signed [DIST_WIDTH-1:0] known_diag_d;

   modport source (
      output valid, mode, rest_dist, pos_x_dist, pos_z_dist, neg_x_dist, neg_z_dist,
             known_axis, known_diag_a, known_diag_b, known_diag_c, known_diag_d,
      input  ready
   );
   modport sink (
      input  valid, mode, rest_dist, pos_x_dist, pos_z_dist, neg_x_dist, neg_z_dist,
             known_axis, known_diag_a, known_diag_b, known_diag_c, known_diag_d,
      output ready
   );
endinterface

// ----- hdl/lbmzh_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lbmzh_rsp_if
// Response channel: the five reconstructed distributions.
// ----------------------------------------------------------------------------
interface lbmzh_rsp_if #(
   parameter int DIST_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DIST_WIDTH-1:0] new_axis;
   logic signed [DIST_WIDTH-1:0] new_diag_a;
   logic signed [DIST_WIDTH-1:0] new_diag_b;
   logic signed [DIST_WIDTH-1:0] new_diag_c;
   logic signed [DIST_WIDTH-1:0] new_diag_d;

   modport source (
      output valid, new_axis, new_diag_a, new_diag_b, new_diag_c, new_diag_d,
      input  ready
   );
   modport sink (
      input  valid, new_axis, new_diag_a, new_diag_b, new_diag_c, new_diag_d,
      output ready
   );
endinterface

// ----- hdl/lbmzh_csr_if.sv -----
// ----------------------------------------------------------------------------
// lbmzh_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface lbmzh_csr_if
   import lbmzh_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [VEL_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/lbm_d3q15_wall_velocity_boundary.sv -----
// Throughput: one request per cycle while no response is held; the long divider pipeline (one quotient bit
// per stage, DIST_WIDTH + 21 stages, five lanes) sets the latency.
// The whole pipeline holds while a response waits on the output register.
// Reset: velocity registers clear to zero, all stage valid bits clear.
// ----------------------------------------------------------------------------
// lbm_d3q15_wall_velocity_boundary
// Zou-He moving-wall boundary for D3Q15 plate nodes, fixed point, pipelined.
// ----------------------------------------------------------------------------
module lbm_d3q15_wall_velocity_boundary
   import lbmzh_pkg::*;
#(
   parameter int DIST_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   lbmzh_req_if.sink   req_if,
   lbmzh_rsp_if.source rsp_if,
   lbmzh_csr_if.sink   csr_if
);

   localparam int W     = DIST_WIDTH;
   localparam int PS_W  = W + 3;            // sum of five terms
   localparam int S_W   = W + 4;            // full node sum
   localparam int SMAG  = W + 3;            // magnitude of node sum
   localparam int LO_W  = SMAG / 2;
   localparam int HI_W  = SMAG - LO_W;
   localparam int PW    = SMAG + KMAG_W;    // product / quotient width
   localparam int QW    = W + 2;
   localparam int SW    = ((W > TERM_W) ? W : TERM_W) + 2;

   localparam logic signed [TERM_W-1:0] TERM_CAP = TERM_W'(1) << CAP_BIT;
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   typedef logic signed [W-1:0] dist_type;

   typedef struct packed {
      logic signed [PS_W-1:0]           sfree;
      logic signed [PS_W-1:0]           swall;
      logic [LANES-1:0][K_W-1:0]        k;
      logic [D_W-1:0]                   d;
      logic [LANES-1:0][W-1:0]          known;
      logic [LANES-1:0][W-1:0]          quarter;
   } s1_type;

   typedef struct packed {
      logic [SMAG-1:0]                  smag;
      logic [LANES-1:0][KMAG_W-1:0]     kmag;
      logic [LANES-1:0]                 neg;
      logic [M_W-1:0]                   m;
      logic [LANES-1:0][W-1:0]          known;
      logic [LANES-1:0][W-1:0]          quarter;
   } s2_type;

   typedef struct packed {
      logic [LANES-1:0][LO_W+KMAG_W-1:0] pp_lo;
      logic [LANES-1:0][HI_W+KMAG_W-1:0] pp_hi;
      logic [LANES-1:0]                  neg;
      logic [M_W-1:0]                    m;
      logic [LANES-1:0][W-1:0]           known;
      logic [LANES-1:0][W-1:0]           quarter;
   } s3_type;

   typedef struct packed {
      logic [LANES-1:0][M_W-1:0]        rem;
      logic [LANES-1:0][PW-1:0]         pq;
      logic [LANES-1:0]                 neg;
      logic [M_W-1:0]                   m;
      logic [LANES-1:0][W-1:0]          known;
      logic [LANES-1:0][W-1:0]          quarter;
   } div_type;

   typedef struct packed {
      logic [LANES-1:0][TERM_W-1:0]     term;
      logic [LANES-1:0][W-1:0]          known;
      logic [LANES-1:0][W-1:0]          quarter;
   } f1_type;

   // configuration
   vel_type vel_ff [0:5];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) vel_ff[i] <= '0;
      end else if (csr_if.valid) begin
         case (csr_reg_type'(csr_if.index))
            REG_LOWER_VEL_X: vel_ff[REG_LOWER_VEL_X] <= clamp_vel(csr_if.data);
            REG_LOWER_VEL_Y: vel_ff[REG_LOWER_VEL_Y] <= clamp_vel(csr_if.data);
            REG_LOWER_VEL_Z: vel_ff[REG_LOWER_VEL_Z] <= clamp_vel(csr_if.data);
            REG_UPPER_VEL_X: vel_ff[REG_UPPER_VEL_X] <= clamp_vel(csr_if.data);
            REG_UPPER_VEL_Y: vel_ff[REG_UPPER_VEL_Y] <= clamp_vel(csr_if.data);
            REG_UPPER_VEL_Z: vel_ff[REG_UPPER_VEL_Z] <= clamp_vel(csr_if.data);
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   // pipeline control
   logic en;
   logic out_valid_ff;
   logic v1_ff, v2_ff, v3_ff, f1_valid_ff;
   logic [PW:0] dv_ff;

   assign en           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = en;

   // stage 1: mode select, partial sums, velocity factors, quarter parts
   s1_type  s1_in, s1_ff;
   vel_type u, vy, w, sv;
   logic signed [VEL_W:0]  uw, wmu, d_wide;
   logic signed [K_W-1:0]  uw3, wmu3, svk;
   logic signed [W:0]      dx, dz;
   logic signed [QW-1:0]   qa, qb, qc, qd;

   always_comb begin
      u  = req_if.mode ? vel_ff[REG_UPPER_VEL_X] : vel_ff[REG_LOWER_VEL_X];
      vy = req_if.mode ? vel_ff[REG_UPPER_VEL_Y] : vel_ff[REG_LOWER_VEL_Y];
      w  = req_if.mode ? vel_ff[REG_UPPER_VEL_Z] : vel_ff[REG_LOWER_VEL_Z];
      sv = req_if.mode ? -vy : vy;
      d_wide = req_if.mode ? ((VEL_W+1)'(32768) + (VEL_W+1)'(vy))
                           : ((VEL_W+1)'(32768) - (VEL_W+1)'(vy));
      uw   = (VEL_W+1)'(u) + (VEL_W+1)'(w);
      wmu  = (VEL_W+1)'(w) - (VEL_W+1)'(u);
      uw3  = (K_W'(uw) <<< 1) + K_W'(uw);
      wmu3 = (K_W'(wmu) <<< 1) + K_W'(wmu);
      svk  = K_W'(sv);

      dx = (W+1)'(req_if.pos_x_dist) - (W+1)'(req_if.neg_x_dist);
      dz = (W+1)'(req_if.pos_z_dist) - (W+1)'(req_if.neg_z_dist);
      qa = -QW'(dx) - QW'(dz);
      qb =  QW'(dx) - QW'(dz);
      qc =  QW'(dz) - QW'(dx);
      qd =  QW'(dx) + QW'(dz);

      s1_in.sfree = PS_W'(req_if.rest_dist) + PS_W'(req_if.pos_x_dist)
                  + PS_W'(req_if.pos_z_dist) + PS_W'(req_if.neg_x_dist)
                  + PS_W'(req_if.neg_z_dist);
      s1_in.swall = PS_W'(req_if.known_axis) + PS_W'(req_if.known_diag_a)
                  + PS_W'(req_if.known_diag_b) + PS_W'(req_if.known_diag_c)
                  + PS_W'(req_if.known_diag_d);
      s1_in.k[LANE_AXIS] = svk <<< 3;
      s1_in.k[1] = svk + uw3;
      s1_in.k[2] = svk + wmu3;
      s1_in.k[3] = svk - wmu3;
      s1_in.k[4] = svk - uw3;
      s1_in.d    = d_wide[D_W-1:0];
      s1_in.known[LANE_AXIS] = req_if.known_axis;
      s1_in.known[1] = req_if.known_diag_a;
      s1_in.known[2] = req_if.known_diag_b;
      s1_in.known[3] = req_if.known_diag_c;
      s1_in.known[4] = req_if.known_diag_d;
      // arithmetic shift by two is floor(q / 4)
      s1_in.quarter[LANE_AXIS] = '0;
      s1_in.quarter[1] = qa[QW-1:2];
      s1_in.quarter[2] = qb[QW-1:2];
      s1_in.quarter[3] = qc[QW-1:2];
      s1_in.quarter[4] = qd[QW-1:2];
   end

   // stage 2: node sum, sign/magnitude split, divisor
   s2_type s2_in, s2_ff;
   logic signed [S_W-1:0] s_full;
   logic [S_W-1:0]        s_abs;
   logic signed [K_W-1:0] k_abs;

   always_comb begin
      s_full = S_W'(s1_ff.sfree) + (S_W'(s1_ff.swall) <<< 1);
      s_abs  = s_full[S_W-1] ? S_W'(-s_full) : S_W'(s_full);
      s2_in.smag = s_abs[SMAG-1:0];
      k_abs  = '0;
      for (int i = 0; i < LANES; i++) begin
         k_abs = s1_ff.k[i][K_W-1] ? -signed'(s1_ff.k[i]) : signed'(s1_ff.k[i]);
         s2_in.kmag[i] = k_abs[KMAG_W-1:0];
         s2_in.neg[i]  = s_full[S_W-1] ^ s1_ff.k[i][K_W-1];
      end
      s2_in.m       = (M_W'(s1_ff.d) << 3) + (M_W'(s1_ff.d) << 2);
      s2_in.known   = s1_ff.known;
      s2_in.quarter = s1_ff.quarter;
   end

   // stage 3: split partial products
   s3_type s3_in, s3_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s3_in.pp_lo[i] = (LO_W+KMAG_W)'(s2_ff.smag[LO_W-1:0])
                        * (LO_W+KMAG_W)'(s2_ff.kmag[i]);
         s3_in.pp_hi[i] = (HI_W+KMAG_W)'(s2_ff.smag[SMAG-1:LO_W])
                        * (HI_W+KMAG_W)'(s2_ff.kmag[i]);
      end
      s3_in.neg     = s2_ff.neg;
      s3_in.m       = s2_ff.m;
      s3_in.known   = s2_ff.known;
      s3_in.quarter = s2_ff.quarter;
   end

   // divider: stage 0 assembles the product, then one quotient bit per stage
   div_type div_in [0:PW];
   div_type div_ff [0:PW];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         div_in[0].rem[i] = '0;
         div_in[0].pq[i]  = (PW'(s3_ff.pp_hi[i]) << LO_W) + PW'(s3_ff.pp_lo[i]);
      end
      div_in[0].neg     = s3_ff.neg;
      div_in[0].m       = s3_ff.m;
      div_in[0].known   = s3_ff.known;
      div_in[0].quarter = s3_ff.quarter;
   end

   genvar g;
   generate
      for (g = 1; g <= PW; g++) begin : g_div
         logic [LANES-1:0][M_W:0] t;
         logic [LANES-1:0][M_W:0] diff;
         logic [LANES-1:0]        ge;

         always_comb begin
            for (int i = 0; i < LANES; i++) begin
               t[i]    = {div_ff[g-1].rem[i], div_ff[g-1].pq[i][PW-1]};
               diff[i] = t[i] - {1'b0, div_ff[g-1].m};
               ge[i]   = !diff[i][M_W];
               div_in[g].rem[i] = ge[i] ? diff[i][M_W-1:0] : t[i][M_W-1:0];
               div_in[g].pq[i]  = {div_ff[g-1].pq[i][PW-2:0], ge[i]};
            end
            div_in[g].neg     = div_ff[g-1].neg;
            div_in[g].m       = div_ff[g-1].m;
            div_in[g].known   = div_ff[g-1].known;
            div_in[g].quarter = div_ff[g-1].quarter;
         end
      end
   endgenerate

   // stage F1: clamp, floor toward minus infinity, apply sign
   f1_type f1_in, f1_ff;
   logic [PW-1:0]              q_mag;
   logic signed [TERM_W-1:0]   q_t;
   logic                       inexact;

   always_comb begin
      q_mag   = '0;
      q_t     = '0;
      inexact = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         q_mag   = div_ff[PW].pq[i];
         q_t     = signed'(TERM_W'(q_mag));
         inexact = |div_ff[PW].rem[i];
         if ((q_mag >> CAP_BIT) != '0) begin
            f1_in.term[i] = div_ff[PW].neg[i] ? -TERM_CAP : TERM_CAP;
         end else if (div_ff[PW].neg[i]) begin
            f1_in.term[i] = -q_t - TERM_W'(inexact);
         end else begin
            f1_in.term[i] = q_t;
         end
      end
      f1_in.known   = div_ff[PW].known;
      f1_in.quarter = div_ff[PW].quarter;
   end

   // output stage: final add and saturation
   logic [LANES-1:0][W-1:0] res_in, res_ff;
   logic signed [SW-1:0]    total;

   always_comb begin
      total = '0;
      for (int i = 0; i < LANES; i++) begin
         total = SW'(dist_type'(f1_ff.known[i])) + SW'(dist_type'(f1_ff.quarter[i]))
               + SW'(signed'(f1_ff.term[i]));
         if (total > SAT_HI) begin
            res_in[i] = SAT_HI[W-1:0];
         end else if (total < SAT_LO) begin
            res_in[i] = SAT_LO[W-1:0];
         end else begin
            res_in[i] = total[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         dv_ff        <= '0;
         f1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_if.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         dv_ff        <= {dv_ff[PW-1:0], v3_ff};
         f1_valid_ff  <= dv_ff[PW];
         out_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         for (int k = 0; k <= PW; k++) div_ff[k] <= div_in[k];
         f1_ff  <= f1_in;
         res_ff <= res_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.new_axis   = res_ff[LANE_AXIS];
   assign rsp_if.new_diag_a = res_ff[1];
   assign rsp_if.new_diag_b = res_ff[2];
   assign rsp_if.new_diag_c = res_ff[3];
   assign rsp_if.new_diag_d = res_ff[4];

endmodule
